FILE: rtl/scfr_pkg.sv
// Shared constants and control/status types for the sync checksum frame receiver.
package scfr_pkg;

  // Default payload length of one frame
  localparam int PAYLOAD_BYTES_DEF = 8;

  // Sync pair 'D' then 'b'
  localparam logic [7:0] SYNC_FIRST  = 8'h44;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Failure counter saturation value
  localparam logic [15:0] FAIL_MAX = 16'hFFFF;

  // Result status codes
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;        // clear byte count and running sum
    logic store;      // write received byte, add to sum
    logic chk;        // checksum byte transfer: bump counter on mismatch
    logic rd_start;   // rewind read index
    logic rd_issue;   // read the store at the read index
    logic load_byte;  // load a payload result, advance read index
    logic load_fail;  // load the failure result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_sync1;    // received byte is 'D'
    logic is_sync2;    // received byte is 'b'
    logic last_store;  // this store fills the payload
    logic csum_ok;     // received byte equals inverted sum
    logic rd_last;     // read index at final payload byte
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

FILE: rtl/sync_checksum_frame_receiver.sv
// Top level of the sync checksum frame receiver: controller, datapath and checks.
// Receives one byte per input transfer, hunts for the sync pair 'D','b', stores
// PAYLOAD_BYTES payload bytes and checks the following byte against the inverted
// 8-bit sum. Sync, payload and hunting bytes are taken at one per cycle and give
// no result. A good checksum byte is followed by PAYLOAD_BYTES result transfers,
// each made of a registered read of the payload memory, then a load of the output
// register once it is free; input is stalled meanwhile. A bad checksum gives one
// failure result, loaded from the S_FAIL state once the output register is free,
// and bumps a failure count that holds at 65535. The output register lets input
// continue while a result waits.
module sync_checksum_frame_receiver #(
  parameter int PAYLOAD_BYTES = scfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_byte_position,
  output logic        out_last_of_run,
  output logic [15:0] out_failure_total
);

  scfr_pkg::cmd_t cmd;
  scfr_pkg::sts_t sts;

  // Frame controller
  scfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and result datapath
  scfr_dp #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .rx_byte           (in_rx_byte),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_payload_byte  (out_payload_byte),
    .out_byte_position (out_byte_position),
    .out_last_of_run   (out_last_of_run),
    .out_failure_total (out_failure_total)
  );

  // A failure result carries zero byte and position
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_payload_byte == 8'd0 && out_byte_position == 3'd0)
    else $error("failure result carries nonzero byte or position");

  // A failure result always ends its run
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !out_status)
    else $error("failure result not marked last");

  // Input stays stalled while an unfinished payload run is on the output
  a_run_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> in_stall)
    else $error("input taken in the middle of a payload run");

endmodule

FILE: rtl/scfr_dp.sv
// Datapath: payload store, running sum, failure counter and output register.
module scfr_dp #(
  parameter int PAYLOAD_BYTES = scfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scfr_pkg::cmd_t cmd,
  output scfr_pkg::sts_t sts,
  input  logic [7:0]    rx_byte,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          out_status,
  output logic [7:0]    out_payload_byte,
  output logic [2:0]    out_byte_position,
  output logic          out_last_of_run,
  output logic [15:0]   out_failure_total
);

  localparam int IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CntW = $clog2(PAYLOAD_BYTES + 1);
  localparam int PosW = (IdxW > 3) ? IdxW : 3;

  logic [CntW-1:0] wr_cnt_r, wr_cnt_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [15:0]     fail_cnt_r, fail_cnt_nxt;
  logic [IdxW-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]      rd_data_r;
  logic [7:0]      store_mem [PAYLOAD_BYTES];
  logic [PosW-1:0] pos_ext;

  logic            out_valid_r, out_valid_nxt;
  logic            out_status_r;
  logic [7:0]      out_byte_r;
  logic [2:0]      out_pos_r;
  logic            out_last_r;
  logic [15:0]     out_total_r;

  // Status towards the controller
  always_comb begin
    sts.is_sync1   = (rx_byte == scfr_pkg::SYNC_FIRST);
    sts.is_sync2   = (rx_byte == scfr_pkg::SYNC_SECOND);
    sts.last_store = (wr_cnt_r == CntW'(PAYLOAD_BYTES - 1));
    sts.csum_ok    = (~sum_r == rx_byte);
    sts.rd_last    = (rd_idx_r == IdxW'(PAYLOAD_BYTES - 1));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Count, sum, failure counter and read index
  always_comb begin
    wr_cnt_nxt   = wr_cnt_r;
    sum_nxt      = sum_r;
    fail_cnt_nxt = fail_cnt_r;
    rd_idx_nxt   = rd_idx_r;
    if (cmd.clr) begin
      wr_cnt_nxt = '0;
      sum_nxt    = '0;
    end else if (cmd.store) begin
      wr_cnt_nxt = wr_cnt_r + CntW'(1);
      sum_nxt    = sum_r + rx_byte;
    end else if (cmd.chk) begin
      wr_cnt_nxt = '0;
      sum_nxt    = '0;
      if (!sts.csum_ok && fail_cnt_r != scfr_pkg::FAIL_MAX) begin
        fail_cnt_nxt = fail_cnt_r + 16'd1;
      end
    end
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.load_byte && !sts.rd_last) begin
      rd_idx_nxt = rd_idx_r + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cnt_r   <= '0;
      sum_r      <= '0;
      fail_cnt_r <= '0;
      rd_idx_r   <= '0;
    end else begin
      wr_cnt_r   <= wr_cnt_nxt;
      sum_r      <= sum_nxt;
      fail_cnt_r <= fail_cnt_nxt;
      rd_idx_r   <= rd_idx_nxt;
    end
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      store_mem[wr_cnt_r[IdxW-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= store_mem[rd_idx_r];
    end
  end

  assign pos_ext = PosW'(rd_idx_r);

  // Output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_byte || cmd.load_fail) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_status_r <= scfr_pkg::STATUS_GOOD;
      out_byte_r   <= rd_data_r;
      out_pos_r    <= pos_ext[2:0];
      out_last_r   <= sts.rd_last;
      out_total_r  <= fail_cnt_r;
    end else if (cmd.load_fail) begin
      out_status_r <= scfr_pkg::STATUS_FAIL;
      out_byte_r   <= '0;
      out_pos_r    <= '0;
      out_last_r   <= 1'b1;
      out_total_r  <= fail_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_payload_byte  = out_byte_r;
  assign out_byte_position = out_pos_r;
  assign out_last_of_run   = out_last_r;
  assign out_failure_total = out_total_r;

endmodule

FILE: rtl/scfr_ctrl.sv
// Controller: frame state machine driving the datapath and the input stall.
module scfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  scfr_pkg::sts_t sts,
  output scfr_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_SYNC2,
    S_COLLECT,
    S_CHECK,
    S_READ,
    S_SHOW,
    S_FAIL
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   accept;

  assign accept = in_valid && !in_stall_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (accept && sts.is_sync1) begin
          state_nxt = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (accept) begin
          if (sts.is_sync2) begin
            cmd.clr   = 1'b1;
            state_nxt = S_COLLECT;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_COLLECT: begin
        if (accept) begin
          cmd.store = 1'b1;
          if (sts.last_store) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (accept) begin
          cmd.chk = 1'b1;
          if (sts.csum_ok) begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_READ;
          end else begin
            state_nxt = S_FAIL;
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_SHOW;
      end
      S_SHOW: begin
        if (sts.out_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = sts.rd_last ? S_HUNT : S_READ;
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.load_fail = 1'b1;
          state_nxt     = S_HUNT;
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
    in_stall_nxt = !(state_nxt inside {S_HUNT, S_SYNC2, S_COLLECT, S_CHECK});
  end

  // State and registered stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_HUNT;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule
